// File: design/pft_pkg.sv
// Shared types, codes and helpers for the prefix filter table.
// No dependencies; every other file of the block uses this package.
package pft_pkg;

    // Default number of table entries
    localparam int unsigned TABLE_DEPTH_DEFAULT = 64;

    // Address and length limits
    localparam int unsigned ADDR_W   = 128;
    localparam logic [7:0]  V4_MAX_LEN = 8'd32;
    localparam logic [7:0]  V6_MAX_LEN = 8'd128;

    // Operation codes carried by an input item
    typedef enum logic [1:0] {
        FUNC_ADD_FILTER = 2'd0,
        FUNC_ADD_ASSERT = 2'd1,
        FUNC_QUERY      = 2'd2,
        FUNC_COMMIT     = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CONFLICT = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    // Per-entry flags and stored prefix length
    typedef struct packed {
        logic [7:0] pfx_len;
        logic       is_assert;
        logic       is_ipv6;
        logic       has_prefix;
        logic       has_asn;
    } meta_t;

    // One stored table entry
    typedef struct packed {
        logic [31:0] asn;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        meta_t       meta;
    } entry_t;

    // Limit a prefix length to the width of its address family
    function automatic logic [7:0] clamp_len(input logic [7:0] len, input logic v6);
        logic [7:0] lim;
        lim = v6 ? V6_MAX_LEN : V4_MAX_LEN;
        return (len > lim) ? lim : len;
    endfunction

endpackage

// File: design/prefix_filter_table_top.sv
// Top level of the prefix filter table: sequencer, item registers, result
// register. Depends on pft_pkg, pft_entry_ram and pft_match.
//
// Usage: the input channel (in_valid/in_stall) carries one operation per
// item: add filter, add assertion, query route, or commit pending entries.
// The output channel (out_valid/out_stall) returns exactly one result item
// per input item, in order: status, filtered and has_data.
// An add with a prefix or a query walks the committed entries, one entry
// read from the entry memory per cycle; an add without a prefix, an add
// or query on an empty committed region, and a commit skip the walk. The
// single read port of the entry memory sets this rate. The block holds one
// item at a time; it can take the next item in the cycle after the previous
// result is loaded into the output register, even if that result is still
// stalled. A finished item waits in its last state while the output
// register is full and stalled.
// Reset empties the table (both counts zero) and drops any pending result;
// the entry memory itself is not cleared.
module prefix_filter_table_top #(
    parameter int unsigned TABLE_DEPTH = pft_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic        has_asn,
    input  logic        has_prefix,
    input  logic [31:0] asn,
    input  logic        is_ipv6,
    input  logic [63:0] addr_high,
    input  logic [63:0] addr_low,
    input  logic [7:0]  pfx_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        filtered,
    output logic        has_data
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    pft_pkg::state_t  state_reg, state_next;

    // Held item
    pft_pkg::func_t   func_reg;
    logic             has_asn_reg;
    logic             has_prefix_reg;
    logic [31:0]      asn_reg;
    logic             is_ipv6_reg;
    logic [63:0]      addr_high_reg;
    logic [63:0]      addr_low_reg;
    logic [7:0]       pfx_len_reg;

    // Scan control
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             hit_reg, hit_next;

    // Table counts
    logic [CW-1:0]    committed_count_reg, committed_count_next;
    logic [CW-1:0]    total_count_reg, total_count_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    pft_pkg::status_t status_reg, status_next;
    logic             filtered_reg, filtered_next;
    logic             has_data_reg, has_data_next;

    logic             accept;
    logic             rd_en;
    logic             finish_fire;
    logic             last_read;
    logic             needs_scan;
    logic             is_add;
    logic             conflict;
    logic             full;
    logic             wr_en;
    pft_pkg::entry_t  wr_data;
    pft_pkg::entry_t  rd_data;
    logic             entry_hit;

    // Entry memory
    pft_entry_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (total_count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // Entry comparator
    pft_match u_match (
        .entry     (rd_data),
        .func      (func_reg),
        .asn       (asn_reg),
        .is_ipv6   (is_ipv6_reg),
        .addr_high (addr_high_reg),
        .addr_low  (addr_low_reg),
        .pfx_len   (pfx_len_reg),
        .hit       (entry_hit)
    );

    // Decode the held item
    always_comb
    begin
        is_add     = (func_reg inside {pft_pkg::FUNC_ADD_FILTER, pft_pkg::FUNC_ADD_ASSERT});
        needs_scan = (committed_count_reg != '0)
                     && ((is_add && has_prefix_reg) || (func_reg == pft_pkg::FUNC_QUERY));
        last_read  = ((CW'(rd_addr_reg) + CW'(1)) == committed_count_reg);
        conflict   = is_add && hit_reg;
        full       = (total_count_reg == CW'(TABLE_DEPTH));
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall    = (state_reg != pft_pkg::ST_IDLE);
        accept      = in_valid && (state_reg == pft_pkg::ST_IDLE);
        rd_en       = (state_reg == pft_pkg::ST_SCAN);
        finish_fire = (state_reg == pft_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);
        wr_en       = finish_fire && is_add && !conflict && !full;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pft_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = pft_pkg::ST_SCAN;
            end
            pft_pkg::ST_SCAN:
            begin
                if (!needs_scan)
                    state_next = pft_pkg::ST_FINISH;
                else if (last_read)
                    state_next = pft_pkg::ST_DRAIN;
            end
            pft_pkg::ST_DRAIN:
            begin
                state_next = pft_pkg::ST_FINISH;
            end
            pft_pkg::ST_FINISH:
            begin
                if (finish_fire)
                    state_next = pft_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pft_pkg::ST_IDLE;
            end
        endcase
    end

    // Assemble the entry to append
    always_comb
    begin
        wr_data.asn             = has_asn_reg ? asn_reg : '0;
        wr_data.addr_high       = has_prefix_reg ? addr_high_reg : '0;
        wr_data.addr_low        = has_prefix_reg ? addr_low_reg : '0;
        wr_data.meta.pfx_len    = pfx_len_reg;
        wr_data.meta.is_assert  = (func_reg == pft_pkg::FUNC_ADD_ASSERT);
        wr_data.meta.is_ipv6    = is_ipv6_reg;
        wr_data.meta.has_prefix = has_prefix_reg;
        wr_data.meta.has_asn    = has_asn_reg;
    end

    // Scan pointer, hit flag, counts and result
    always_comb
    begin
        rd_addr_next         = rd_addr_reg;
        rd_pend_next         = rd_en && needs_scan;
        hit_next             = hit_reg;
        committed_count_next = committed_count_reg;
        total_count_next     = total_count_reg;
        out_valid_next       = out_valid_reg && out_stall;
        status_next          = status_reg;
        filtered_next        = filtered_reg;
        has_data_next        = has_data_reg;

        // Start a fresh scan on each new item
        if (accept)
        begin
            rd_addr_next = '0;
            hit_next     = 1'b0;
        end

        // Advance the read pointer
        if (rd_en && needs_scan && !last_read)
            rd_addr_next = rd_addr_reg + AW'(1);

        // Fold in the entry read last cycle
        if (rd_pend_reg && entry_hit)
            hit_next = 1'b1;

        // Retire the item into the result register
        if (finish_fire)
        begin
            if (func_reg == pft_pkg::FUNC_COMMIT)
                committed_count_next = total_count_reg;
            if (wr_en)
                total_count_next = total_count_reg + CW'(1);

            if (conflict)
                status_next = pft_pkg::STATUS_CONFLICT;
            else if (is_add && full)
                status_next = pft_pkg::STATUS_FULL;
            else
                status_next = pft_pkg::STATUS_OK;

            filtered_next  = (func_reg == pft_pkg::FUNC_QUERY) && hit_reg;
            has_data_next  = (committed_count_next != '0);
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= pft_pkg::ST_IDLE;
            rd_pend_reg         <= 1'b0;
            committed_count_reg <= '0;
            total_count_reg     <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            rd_pend_reg         <= rd_pend_next;
            committed_count_reg <= committed_count_next;
            total_count_reg     <= total_count_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= pft_pkg::func_t'(func);
            has_asn_reg    <= has_asn;
            has_prefix_reg <= has_prefix;
            asn_reg        <= asn;
            is_ipv6_reg    <= is_ipv6;
            addr_high_reg  <= addr_high;
            addr_low_reg   <= addr_low;
            pfx_len_reg    <= pfx_len;
        end
        rd_addr_reg  <= rd_addr_next;
        hit_reg      <= hit_next;
        status_reg   <= status_next;
        filtered_reg <= filtered_next;
        has_data_reg <= has_data_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign filtered  = filtered_reg;
    assign has_data  = has_data_reg;

endmodule

// File: design/pft_entry_ram.sv
// Entry storage of the prefix filter table: one write port, one read port,
// registered read data. Depends on pft_pkg for the entry record type.
module pft_entry_ram #(
    parameter int unsigned TABLE_DEPTH = pft_pkg::TABLE_DEPTH_DEFAULT,
    parameter int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  pft_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output pft_pkg::entry_t     rd_data
);

    pft_pkg::entry_t mem [TABLE_DEPTH];
    pft_pkg::entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/pft_match.sv
// Compare one stored entry against the held item: prefix overlap for adds,
// filter match for queries. Depends on pft_pkg.
module pft_match (
    input  pft_pkg::entry_t  entry,
    input  pft_pkg::func_t   func,
    input  logic [31:0]      asn,
    input  logic             is_ipv6,
    input  logic [63:0]      addr_high,
    input  logic [63:0]      addr_low,
    input  logic [7:0]       pfx_len,
    output logic             hit
);

    logic [7:0]                   elen;
    logic [7:0]                   qlen;
    logic [7:0]                   mlen;
    logic                         same_family;
    logic [pft_pkg::ADDR_W-1:0]   mask;
    logic                         bits_eq;
    logic                         covered;
    logic                         asn_eq;

    // Build the mask of the shorter prefix and compare leading bits
    always_comb
    begin
        elen        = pft_pkg::clamp_len(entry.meta.pfx_len, entry.meta.is_ipv6);
        qlen        = pft_pkg::clamp_len(pfx_len, is_ipv6);
        mlen        = (elen <= qlen) ? elen : qlen;
        same_family = (entry.meta.is_ipv6 == is_ipv6);
        mask        = ~({pft_pkg::ADDR_W{1'b1}} >> mlen);
        bits_eq     = ((({entry.addr_high, entry.addr_low} ^ {addr_high, addr_low})
                        & mask) == '0);
        covered     = same_family && (elen <= qlen) && bits_eq;
        asn_eq      = (entry.asn == asn);
    end

    // Select the rule for the operation in progress
    always_comb
    begin
        if (func == pft_pkg::FUNC_QUERY)
        begin
            if (entry.meta.is_assert)
                hit = 1'b0;
            else if (entry.meta.has_asn && entry.meta.has_prefix)
                hit = asn_eq && covered;
            else if (entry.meta.has_asn)
                hit = asn_eq;
            else if (entry.meta.has_prefix)
                hit = covered;
            else
                hit = 1'b0;
        end
        else
        begin
            // Overlap in either direction counts as a conflict
            hit = entry.meta.has_prefix && same_family && bits_eq;
        end
    end

endmodule
